/* src/sidec_pkg.sv */
// Package for the signed integer to decimal ASCII converter.
// Holds the character codes, the BCD adjust helper and the control struct
// that drives the shift-add-3 unit. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sidec_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

  // Commands from the sequencer to the shift-add-3 unit.
  typedef struct packed {
    logic load;  // take a new magnitude and clear the BCD digits
    logic step;  // one shift-add-3 iteration
    logic emit;  // drop the top BCD digit and move the rest up
  } dab_ctrl_t;

  // One BCD digit adjusted before the left shift.
  function automatic logic [3:0] bcd_adjust(input logic [3:0] nib);
    logic [3:0] res;
    res = (nib >= BCD_ADJ_MIN) ? (nib + BCD_ADJ_ADD) : nib;
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/sidec_if.sv */
// Handshake channels of the decimal ASCII converter.
// The input channel carries one signed value, the output channel one character.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface sidec_in_if #(
  parameter int VALUE_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidec_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

/* src/signed_int_to_decimal_ascii_top.sv */
// Top level of the signed integer to decimal ASCII converter: sequencer and
// output register around the shift-add-3 unit.
// Depends on sidec_pkg, sidec_if.sv and sidec_dabble.
//
//   Channel  Dir  Payload                 Per item
//   in_i     in   value[VALUE_BITS-1:0]   one signed integer
//   out_o    out  char_code[7:0], last    one ASCII character, last on the final one
//
// An item is taken while the sequencer is idle, then the magnitude goes
// through the shift-add-3 unit one bit a cycle. Leading zero digits are
// dropped at one a cycle; the scan stops at the first nonzero digit or at
// the ones digit. Then the sign and the digits leave at one character a
// cycle while the output is not stalled. Dropped zeros and emitted digits
// always add up to the NDIG digit positions (ten at VALUE_BITS = 32); the
// dabble loop takes the largest share of an item's time.
// in_i.ready is high only while the sequencer is idle; the last character may
// still wait in the output register then. A stalled output holds the
// sequencer in its sign or digit state. Reset (asynchronous, active low)
// returns the sequencer to idle and empties the output register; no clearing
// pass.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  sidec_in_if.sink  in_i,
  sidec_out_if.source out_o
);
  import sidec_pkg::*;

  // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1);
  // 1233/4096 approximates log10(2) closely enough over the whole range.
  localparam int NDIG  = (((VALUE_BITS - 1) * 1233) / 4096) + 1;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int DIG_W = $clog2(NDIG + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIG_W-1:0] dig_left_q;
  logic             neg_q;
  logic             out_valid_q;
  logic [7:0]       char_q;
  logic             last_q;

  logic                  in_accept;
  logic                  out_free;
  logic                  char_load;
  logic                  skip_zero;
  logic [VALUE_BITS-1:0] mag;
  logic [3:0]            digit;
  dab_ctrl_t             ctrl;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  // Magnitude taken as unsigned, so the most negative value becomes
  // 2^(VALUE_BITS-1) and nothing overflows.
  assign mag = in_i.value[VALUE_BITS-1] ? (VALUE_BITS'(0) - VALUE_BITS'(in_i.value))
                                        : VALUE_BITS'(in_i.value);

  // The output register can take a character when empty or being drained.
  assign out_free  = !out_valid_q || out_o.ready;
  // A new character enters the output register this cycle.
  assign char_load = ((state_q == ST_SIGN) || (state_q == ST_DIGIT)) && out_free;
  // Leading zeros are dropped, but the ones digit always stays.
  assign skip_zero = (digit == 4'd0) && (dig_left_q > DIG_W'(1));

  always_comb begin
    ctrl.load = in_accept;
    ctrl.step = (state_q == ST_CONV);
    ctrl.emit = ((state_q == ST_SKIP) && skip_zero) ||
                ((state_q == ST_DIGIT) && out_free);
  end

  sidec_dabble #(
    .MAG_BITS (VALUE_BITS),
    .NDIG     (NDIG)
  ) u_dabble (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .mag_i   (mag),
    .digit_o (digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dig_left_q  <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (char_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            neg_q   <= in_i.value[VALUE_BITS-1];
            cnt_q   <= CNT_W'(VALUE_BITS);
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            dig_left_q <= DIG_W'(NDIG);
            state_q    <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip_zero) begin
            dig_left_q <= dig_left_q - DIG_W'(1);
          end else begin
            state_q <= neg_q ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            char_q      <= CHAR_MINUS;
            last_q      <= 1'b0;
            state_q     <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (out_free) begin
            char_q      <= CHAR_ZERO + {4'd0, digit};
            last_q      <= (dig_left_q == DIG_W'(1));
            dig_left_q  <= dig_left_q - DIG_W'(1);
            if (dig_left_q == DIG_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last      = last_q;

  // Taking a value always starts a conversion that blocks the input.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_i.ready)
    else $error("input still ready after a value was taken");

  // The sign never ends a text.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (char_q == CHAR_MINUS)) |-> !last_q)
    else $error("minus sign flagged as last character");

  // Every other character is a decimal digit.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (char_q != CHAR_MINUS)) |->
      ((char_q >= CHAR_ZERO) && (char_q <= (CHAR_ZERO + 8'd9))))
    else $error("character is neither a sign nor a digit");

  // While idle, a pending character can only be the end of the previous text.
  a_idle_pending_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.ready && out_valid_q) |-> last_q)
    else $error("idle with an unfinished text in the output register");

endmodule

`default_nettype wire

/* src/sidec_dabble.sv */
// Shift-add-3 (double dabble) unit of the decimal ASCII converter.
// Turns a binary magnitude into BCD one bit a cycle, then hands the digits
// out from the top. Depends on sidec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sidec_dabble #(
  parameter int MAG_BITS = 32,
  parameter int NDIG     = 10
) (
  input  wire logic                  clk_i,
  input  wire sidec_pkg::dab_ctrl_t  ctrl_i,
  input  wire logic [MAG_BITS-1:0]   mag_i,
  output logic      [3:0]            digit_o
);
  import sidec_pkg::*;

  localparam int BCD_W = 4 * NDIG;

  logic [MAG_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]    bcd_q, bcd_d, adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = bcd_adjust(bcd_q[4*i +: 4]);
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (ctrl_i.load) begin
      bin_d = mag_i;
      bcd_d = '0;
    end else if (ctrl_i.step) begin
      bin_d = bin_q << 1;
      bcd_d = {adj[BCD_W-2:0], bin_q[MAG_BITS-1]};
    end else if (ctrl_i.emit) begin
      bcd_d = bcd_q << 4;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign digit_o = bcd_q[BCD_W-1 -: 4];

endmodule

`default_nettype wire
